### hw/rtl/avr_pkg.sv
// ----------------------------------------------------------------------------
// avr_pkg: shared types and constants for the axis-angle rotator
// Coordinate and coefficient widths, register indexes and the quarter-wave
// sine table that is built at elaboration.
// ----------------------------------------------------------------------------
package avr_pkg;

  localparam int COORD_WIDTH     = 24;
  localparam int ANGLE_BITS      = 16;
  localparam int SINE_TABLE_BITS = 10;

  localparam int AXIS_WIDTH = 16;   // Q1.14 axis and trig coefficients
  localparam int RND_SHIFT  = 14;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_AXIS_X     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_Y     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_Z     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_ANGLE = 4'd3;

  localparam int ROM_SIZE = (1 << SINE_TABLE_BITS) + 1;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [AXIS_WIDTH-1:0]  axis_t;
  typedef logic [AXIS_WIDTH-1:0]         rom_word_t;
  typedef rom_word_t                     rom_t [ROM_SIZE];

  localparam longint TAYLOR_DIV [1:8] = '{6, 20, 42, 72, 110, 156, 210, 272};

  // Taylor series in Q2.30, rounded to Q1.14 and capped at one
  function automatic rom_t build_sine_rom();
    rom_t   rom;
    longint x;
    longint x2;
    longint term;
    longint sum;
    longint q;
    for (int i = 0; i < ROM_SIZE; i++) begin
      x    = (longint'(i) * HALF_PI_Q30) >>> SINE_TABLE_BITS;
      x2   = (x * x) >>> 30;
      term = x;
      sum  = x;
      for (int n = 1; n <= 8; n++) begin
        term = ((term * x2) >>> 30) / TAYLOR_DIV[n];
        if (n % 2 == 1) sum = sum - term;
        else            sum = sum + term;
      end
      if (sum < 0) sum = 0;
      q = (sum + 32768) >>> 16;
      if (q > 16384) q = 16384;
      rom[i] = rom_word_t'(q);
    end
    return rom;
  endfunction

endpackage

### hw/rtl/avr_if.sv
// ----------------------------------------------------------------------------
// avr_if: stream and configuration channels of the axis-angle rotator
// Valid/ready channels for positions, rotated results and register writes.
// ----------------------------------------------------------------------------
interface avr_pos_if;
  logic            valid;
  logic            ready;
  avr_pkg::coord_t pos_x;
  avr_pkg::coord_t pos_y;
  avr_pkg::coord_t pos_z;
  logic            in_last;
  modport source (output valid, pos_x, pos_y, pos_z, in_last, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, in_last, output ready);
endinterface

interface avr_res_if;
  logic            valid;
  logic            ready;
  avr_pkg::coord_t out_x;
  avr_pkg::coord_t out_y;
  avr_pkg::coord_t out_z;
  logic            out_last;
  modport source (output valid, out_x, out_y, out_z, out_last, input ready);
  modport sink   (input valid, out_x, out_y, out_z, out_last, output ready);
endinterface

interface avr_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [avr_pkg::CFG_IDX_W-1:0]    index;
  logic [avr_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/axis_angle_vector_rotation.sv
// ----------------------------------------------------------------------------
// axis_angle_vector_rotation: Rodrigues rotation of a position stream
// v' = v*cos + (k x v)*sin + k*(k.v)*(1-cos), saturated to Q11.12.
// ----------------------------------------------------------------------------
// Channels: pos (sink) takes one position a cycle with its frame mark while
// ready is high; res (source) gives one rotated position per input item, in
// order; cfg (sink) writes axis_x, axis_y, axis_z and turn_angle by index;
// the user must write them between frames, the block does not enforce it.
// Items pass a six-stage multiply/round pipeline to res. Throughput: one item
// per cycle while res is ready and no turn_angle lookup is pending. Writing
// turn_angle reads the quarter-wave sine table (registered ROM), then latches
// cosine and sine, with cfg and pos ready low until then; other writes do not.
// Reset (rst, synchronous) empties the pipeline and restores the axis to
// +y and the angle to zero (cosine one, sine zero).
// When res stalls, each stage holds until the one after it has room, so
// bubbles close up and pos stays ready until the whole pipeline is full.
// ----------------------------------------------------------------------------
module axis_angle_vector_rotation (
  input  logic               clk,
  input  logic               rst,
  avr_pos_if.sink            pos,
  avr_res_if.source          res,
  avr_cfg_if.sink            cfg
);

  localparam int CW   = avr_pkg::COORD_WIDTH;
  localparam int AW   = avr_pkg::AXIS_WIDTH;
  localparam int SH   = avr_pkg::RND_SHIFT;
  localparam int TB   = avr_pkg::SINE_TABLE_BITS;
  localparam int QB   = avr_pkg::ANGLE_BITS - 2;
  localparam int SH_R = (QB >= TB) ? QB - TB : 0;
  localparam int SH_L = (QB >= TB) ? 0 : TB - QB;
  localparam int PW   = CW + AW;          // axis times coordinate
  localparam int CRW  = PW + 1 - SH;      // rounded cross product
  localparam int DW   = PW + 2 - SH;      // rounded dot product
  localparam int EPW  = AW + DW;
  localparam int EW   = EPW - SH;
  localparam int OW   = AW + 1;           // one minus cosine
  localparam int VCW  = CW + AW;
  localparam int CSW  = CRW + AW;
  localparam int EOW  = EW + OW;
  localparam int MW0  = (VCW > CSW) ? VCW : CSW;
  localparam int MW1  = (MW0 > EOW) ? MW0 : EOW;
  localparam int SW   = MW1 + 2;
  localparam int RW   = SW + 1 - SH;

  localparam avr_pkg::rom_t SINE_ROM = avr_pkg::build_sine_rom();
  localparam logic [TB:0] FULL = (TB+1)'(1 << TB);
  localparam logic signed [AW-1:0] ONE = AW'(16384);
  localparam logic signed [RW-1:0] SAT_MAX = RW'((64'sd1 <<< (CW - 1)) - 1);
  localparam logic signed [RW-1:0] SAT_MIN = RW'(-(64'sd1 <<< (CW - 1)));

  // configuration
  avr_pkg::axis_t ax, ay, az, cosv, sinv;
  logic           lk_busy, lk_read;
  logic [TB-1:0]  lk_j;
  logic [1:0]     lk_quad;
  logic [AW-1:0]  rom_lo, rom_hi;
  logic [avr_pkg::ANGLE_BITS-1:0] ang;
  logic [QB+TB-1:0] ang_frac;

  assign cfg.ready = !lk_busy;
  assign ang       = avr_pkg::ANGLE_BITS'(cfg.data);
  assign ang_frac  = ((QB+TB)'(ang[QB-1:0]) >> SH_R) << SH_L;

  always_ff @(posedge clk) begin
    if (rst) begin
      ax      <= '0;
      ay      <= ONE;
      az      <= '0;
      cosv    <= ONE;
      sinv    <= '0;
      lk_busy <= 1'b0;
      lk_read <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          avr_pkg::REG_AXIS_X: ax <= cfg.data;
          avr_pkg::REG_AXIS_Y: ay <= cfg.data;
          avr_pkg::REG_AXIS_Z: az <= cfg.data;
          avr_pkg::REG_TURN_ANGLE: begin
            lk_busy <= 1'b1;
            lk_read <= 1'b1;
            lk_quad <= ang[QB+1:QB];
            lk_j    <= ang_frac[TB-1:0];
          end
          default: ;
        endcase
      end
      if (lk_read) begin
        lk_read <= 1'b0;
      end else if (lk_busy) begin
        lk_busy <= 1'b0;
        case (lk_quad)
          2'd0: begin sinv <= rom_lo;  cosv <= rom_hi;  end
          2'd1: begin sinv <= rom_hi;  cosv <= -rom_lo; end
          2'd2: begin sinv <= -rom_lo; cosv <= -rom_hi; end
          default: begin sinv <= -rom_hi; cosv <= rom_lo; end
        endcase
      end
    end
  end

  // sine table, registered reads
  always_ff @(posedge clk) begin
    rom_lo <= SINE_ROM[{1'b0, lk_j}];
    rom_hi <= SINE_ROM[FULL - {1'b0, lk_j}];
  end

  // pipeline
  logic v1, v2, v3, v4, v5, v6;
  logic en1, en2, en3, en4, en5, en6;
  logic l1, l2, l3, l4, l5;

  assign en6 = !v6 || res.ready;
  assign en5 = !v5 || en6;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign pos.ready = en1 && !lk_busy;

  logic signed [PW-1:0]  p_yz, p_zy, p_zx, p_xz, p_xy, p_yx, p_xx, p_yy, p_zz;
  logic signed [VCW-1:0] vc1x, vc1y, vc1z, vc2x, vc2y, vc2z, vc3x, vc3y, vc3z;
  logic signed [CRW-1:0] crx, cry, crz;
  logic signed [DW-1:0]  dd;
  logic signed [CSW-1:0] csx, csy, csz;
  logic signed [EPW-1:0] edx, edy, edz;
  logic signed [EW-1:0]  ex, ey, ez;
  logic signed [SW-1:0]  pa4x, pa4y, pa4z, pa5x, pa5y, pa5z;
  logic signed [EOW-1:0] eox, eoy, eoz;
  logic signed [OW-1:0]  omc;

  // rounding sums: add half, keep the upper bits
  logic signed [PW+1:0]  cr_sx, cr_sy, cr_sz;
  logic signed [PW+2:0]  d_s;
  logic signed [EPW:0]   e_sx, e_sy, e_sz;
  logic signed [SW:0]    o_sx, o_sy, o_sz;
  logic signed [RW-1:0]  rx, ry, rz;

  assign omc = OW'(ONE) - OW'(cosv);

  assign cr_sx = (PW+2)'(p_yz) - (PW+2)'(p_zy) + (PW+2)'(8192);
  assign cr_sy = (PW+2)'(p_zx) - (PW+2)'(p_xz) + (PW+2)'(8192);
  assign cr_sz = (PW+2)'(p_xy) - (PW+2)'(p_yx) + (PW+2)'(8192);
  assign d_s   = (PW+3)'(p_xx) + (PW+3)'(p_yy) + (PW+3)'(p_zz) + (PW+3)'(8192);
  assign e_sx  = (EPW+1)'(edx) + (EPW+1)'(8192);
  assign e_sy  = (EPW+1)'(edy) + (EPW+1)'(8192);
  assign e_sz  = (EPW+1)'(edz) + (EPW+1)'(8192);
  assign o_sx  = (SW+1)'(pa5x) + (SW+1)'(eox) + (SW+1)'(8192);
  assign o_sy  = (SW+1)'(pa5y) + (SW+1)'(eoy) + (SW+1)'(8192);
  assign o_sz  = (SW+1)'(pa5z) + (SW+1)'(eoz) + (SW+1)'(8192);
  assign rx    = o_sx[SW:SH];
  assign ry    = o_sy[SW:SH];
  assign rz    = o_sz[SW:SH];

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6} <= '0;
    end else begin
      if (en1) v1 <= pos.valid && pos.ready;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
      if (en6) v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      p_yz <= ay * pos.pos_z;
      p_zy <= az * pos.pos_y;
      p_zx <= az * pos.pos_x;
      p_xz <= ax * pos.pos_z;
      p_xy <= ax * pos.pos_y;
      p_yx <= ay * pos.pos_x;
      p_xx <= ax * pos.pos_x;
      p_yy <= ay * pos.pos_y;
      p_zz <= az * pos.pos_z;
      vc1x <= pos.pos_x * cosv;
      vc1y <= pos.pos_y * cosv;
      vc1z <= pos.pos_z * cosv;
      l1   <= pos.in_last;
    end
    if (en2) begin
      crx  <= cr_sx[PW:SH];
      cry  <= cr_sy[PW:SH];
      crz  <= cr_sz[PW:SH];
      dd   <= d_s[PW+1:SH];
      vc2x <= vc1x;
      vc2y <= vc1y;
      vc2z <= vc1z;
      l2   <= l1;
    end
    if (en3) begin
      csx  <= crx * sinv;
      csy  <= cry * sinv;
      csz  <= crz * sinv;
      edx  <= ax * dd;
      edy  <= ay * dd;
      edz  <= az * dd;
      vc3x <= vc2x;
      vc3y <= vc2y;
      vc3z <= vc2z;
      l3   <= l2;
    end
    if (en4) begin
      ex   <= e_sx[EPW-1:SH];
      ey   <= e_sy[EPW-1:SH];
      ez   <= e_sz[EPW-1:SH];
      pa4x <= SW'(vc3x) + SW'(csx);
      pa4y <= SW'(vc3y) + SW'(csy);
      pa4z <= SW'(vc3z) + SW'(csz);
      l4   <= l3;
    end
    if (en5) begin
      eox  <= ex * omc;
      eoy  <= ey * omc;
      eoz  <= ez * omc;
      pa5x <= pa4x;
      pa5y <= pa4y;
      pa5z <= pa4z;
      l5   <= l4;
    end
    if (en6) begin
      res.out_x    <= (rx > SAT_MAX) ? CW'(SAT_MAX) : (rx < SAT_MIN) ? CW'(SAT_MIN) : CW'(rx);
      res.out_y    <= (ry > SAT_MAX) ? CW'(SAT_MAX) : (ry < SAT_MIN) ? CW'(SAT_MIN) : CW'(ry);
      res.out_z    <= (rz > SAT_MAX) ? CW'(SAT_MAX) : (rz < SAT_MIN) ? CW'(SAT_MIN) : CW'(rz);
      res.out_last <= l5;
    end
  end

  assign res.valid = v6;

endmodule
